// ===== sv/dcss_pkg.sv =====
// Shared widths, limits and types for the column shadow scan block.
package dcss_pkg;

    // Field widths
    localparam int HEIGHT_W   = 24;
    localparam int COLUMN_W   = 12;
    localparam int DIST_W     = 12;
    localparam int SLOPE_W    = 32;

    // Scan limits
    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;

    // Height is Q.8, slope is Q.16: scale height up to meet the slope
    localparam int FRAC_SHIFT = 8;

    // Product of slope and distance, and the threshold with headroom
    localparam int PROD_W = SLOPE_W + DIST_W + 1;
    localparam int THR_W  = PROD_W + 1;

    // Columns that own an entry in the per-column store
    localparam bit ALL_COLS  = (MAX_COLUMNS >= (2 ** COLUMN_W));
    localparam int RAM_DEPTH = ALL_COLS ? (2 ** COLUMN_W) : MAX_COLUMNS;
    localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam logic [COLUMN_W-1:0] COL_LIM = COLUMN_W'(ALL_COLS ? 0 : MAX_COLUMNS);

    // Row distance saturates at the smaller of the row count less one and the field maximum
    localparam int DIST_LIM_I = ((MAX_ROWS - 1) < ((2 ** DIST_W) - 1)) ?
                                (MAX_ROWS - 1) : ((2 ** DIST_W) - 1);
    localparam logic [DIST_W-1:0] DIST_LIM = DIST_W'(DIST_LIM_I);
    localparam logic [DIST_W-1:0] DIST_ONE = DIST_W'(1);

    // Per-column occluder state
    typedef struct packed {
        logic signed [HEIGHT_W-1:0] occ;
        logic        [DIST_W-1:0]   distance;
    } t_state;

    localparam int STATE_W = $bits(t_state);

endpackage

// ===== sv/dcss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dcss_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read the old contents on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dem_column_shadow_scan.sv =====
// Column-wise line-of-sight shadow scan over a raster elevation stream.
//
// Input channel: i_valid / o_stall carry one sample per beat (height, column,
// first-row flag). Output channel: o_valid / i_stall carry one result per
// sample: height and column passed through and the shadow flag.
// Config: i_cfg_we writes i_cfg_wdata into the signed Q15.16 ray slope; write
// it only while no beat is in flight.
//
// An accepted beat passes through stage 1 and stage 2 into the output
// register, where it shows on o_valid; one beat is taken every cycle while
// o_stall is low. Stage 1 holds the per-column occluder memory read and
// forms slope times distance on one 32x13 multiplier, stage 2 adds and
// compares and writes the memory back, stage 3 is the output register.
// Results from the two beats still ahead in the pipe are forwarded by column
// match.
//
// When the output register holds a beat and i_stall is high the whole pipe
// freezes and o_stall is raised; otherwise input keeps flowing.
// Reset clears the pipe valids and sets the slope to 0. The occluder memory
// is not cleared: each column must start with a first-row sample.
module dem_column_shadow_scan (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [dcss_pkg::HEIGHT_W-1:0] i_height,
    input  logic        [dcss_pkg::COLUMN_W-1:0] i_column,
    input  logic                                 i_first_row,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [dcss_pkg::HEIGHT_W-1:0] o_height_out,
    output logic        [dcss_pkg::COLUMN_W-1:0] o_column_out,
    output logic                                 o_shadowed,
    input  logic                                 i_cfg_we,
    input  logic signed [dcss_pkg::SLOPE_W-1:0]  i_cfg_wdata
);
    import dcss_pkg::*;

    logic w_en;
    logic signed [SLOPE_W-1:0] r_slope;

    // Stage 1: sample plus memory read data
    logic                       r_s1_valid;
    logic                       r_s1_inr;
    logic                       r_s1_first;
    logic signed [HEIGHT_W-1:0] r_s1_height;
    logic        [COLUMN_W-1:0] r_s1_column;
    logic        [STATE_W-1:0]  w_ram_rdata;
    t_state                     w_ram_st;
    t_state                     w_s1_prev;
    t_state                     w_s1_st;
    logic                       w_s1_match2;
    logic                       w_s1_match3;
    logic        [DIST_W:0]     w_s1_dsum;
    logic signed [PROD_W-1:0]   w_s1_prod;

    // Stage 2: predicted state and product, compare
    logic                       r_s2_valid;
    logic                       r_s2_inr;
    logic                       r_s2_first;
    logic                       r_s2_dep;
    logic signed [HEIGHT_W-1:0] r_s2_height;
    logic        [COLUMN_W-1:0] r_s2_column;
    t_state                     r_s2_st;
    logic signed [PROD_W-1:0]   r_s2_prod;
    logic                       w_s2_reset_prev;
    t_state                     w_s2_st;
    logic signed [PROD_W-1:0]   w_s2_prod;
    logic signed [THR_W-1:0]    w_s2_thr;
    logic signed [THR_W-1:0]    w_s2_hscaled;
    logic                       w_s2_shadow;
    t_state                     w_s2_new;
    logic                       w_ram_we;

    // Output register
    logic                       r_out_valid;
    logic                       r_out_inr;
    logic signed [HEIGHT_W-1:0] r_out_height;
    logic        [COLUMN_W-1:0] r_out_column;
    logic                       r_out_shadowed;
    t_state                     r_out_st;

    // Advance the whole pipe unless a held result is stalled
    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    // Per-column occluder store
    dcss_ram #(
        .WIDTH (STATE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_s2_column[ADDR_W-1:0]),
        .i_wdata (w_s2_new),
        .i_re    (w_en),
        .i_raddr (i_column[ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign w_ram_st = w_ram_rdata;

    // Stage 1: pick the freshest state for this column
    assign w_s1_match2 = r_s2_valid && r_s2_inr && (r_s2_column == r_s1_column);
    assign w_s1_match3 = r_out_valid && r_out_inr && (r_out_column == r_s1_column);

    always_comb begin
        priority if (w_s1_match2) begin
            w_s1_prev = w_s2_st;
        end else if (w_s1_match3) begin
            w_s1_prev = r_out_st;
        end else begin
            w_s1_prev = w_ram_st;
        end
    end

    // Stage 1: advance the distance with saturation and scale the slope
    assign w_s1_dsum = {1'b0, w_s1_prev.distance} + (DIST_W + 1)'(1);

    always_comb begin
        w_s1_st.occ      = w_s1_prev.occ;
        w_s1_st.distance = (w_s1_dsum > {1'b0, DIST_LIM}) ? DIST_LIM :
                           w_s1_dsum[DIST_W-1:0];
    end

    assign w_s1_prod = r_slope * $signed({1'b0, w_s1_st.distance});

    // Stage 2: if the beat ahead in this column became the occluder, restart
    assign w_s2_reset_prev = r_s2_dep && !r_out_shadowed;

    always_comb begin
        if (w_s2_reset_prev) begin
            w_s2_st.occ      = r_out_height;
            w_s2_st.distance = DIST_ONE;
            w_s2_prod        = PROD_W'(r_slope);
        end else begin
            w_s2_st          = r_s2_st;
            w_s2_prod        = r_s2_prod;
        end
    end

    // Stage 2: exact threshold and compare
    assign w_s2_thr     = (THR_W'($signed(w_s2_st.occ)) <<< FRAC_SHIFT) + THR_W'(w_s2_prod);
    assign w_s2_hscaled = THR_W'(r_s2_height) <<< FRAC_SHIFT;
    assign w_s2_shadow  = r_s2_inr && !r_s2_first && (w_s2_hscaled < w_s2_thr);

    always_comb begin
        if (w_s2_shadow) begin
            w_s2_new = w_s2_st;
        end else begin
            w_s2_new.occ      = r_s2_height;
            w_s2_new.distance = '0;
        end
    end

    assign w_ram_we = w_en && r_s2_valid && r_s2_inr;

    // Hold slope and pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slope <= i_cfg_wdata;
            end
            if (w_en) begin
                r_s1_valid  <= i_valid;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Advance pipe payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_inr       <= ALL_COLS || (i_column < COL_LIM);
            r_s1_first     <= i_first_row;
            r_s1_height    <= i_height;
            r_s1_column    <= i_column;

            r_s2_inr       <= r_s1_inr;
            r_s2_first     <= r_s1_first;
            r_s2_dep       <= w_s1_match2;
            r_s2_height    <= r_s1_height;
            r_s2_column    <= r_s1_column;
            r_s2_st        <= w_s1_st;
            r_s2_prod      <= w_s1_prod;

            r_out_inr      <= r_s2_inr;
            r_out_height   <= r_s2_height;
            r_out_column   <= r_s2_column;
            r_out_shadowed <= w_s2_shadow;
            r_out_st       <= w_s2_new;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_height_out = r_out_height;
    assign o_column_out = r_out_column;
    assign o_shadowed   = r_out_shadowed;

endmodule

// ===== sv/dcss_checker.sv =====
// Port-level checks for the column shadow scan block, bound to the top level.
module dcss_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_stall,
    input  logic signed [dcss_pkg::HEIGHT_W-1:0] i_height,
    input  logic        [dcss_pkg::COLUMN_W-1:0] i_column,
    input  logic                                 i_first_row,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic signed [dcss_pkg::HEIGHT_W-1:0] o_height_out,
    input  logic        [dcss_pkg::COLUMN_W-1:0] o_column_out,
    input  logic                                 o_shadowed
);

    // Hold a result that the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    // Stall input only behind a stalled, held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

    // Deliver an accepted beat in order when the output flows
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall |=>
        (o_valid && (o_column_out == $past(i_column, 3)) &&
         (o_height_out == $past(i_height, 3))))
        else $error("beat not delivered in order after three cycles");

    // Never mark a first-row beat as shadowed
    a_first_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_first_row) ##1 !i_stall ##1 !i_stall |=>
        !o_shadowed)
        else $error("first-row beat reported shadowed");

    // Keep a stalled result's payload steady
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_height_out) && $stable(o_column_out) &&
                                  $stable(o_shadowed)))
        else $error("stalled result changed");

endmodule

bind dem_column_shadow_scan dcss_checker u_checker (.*);
